// ===== src/sbs_pkg.sv =====
// Package for the sorted table binary search unit.
// Holds the transaction structs, the sequencer state type and the midpoint helper.
// No dependencies; imported by sorted_table_binary_search_unit.
`timescale 1ns / 1ps

package sbs_pkg;

    localparam int IDX_W  = 7;   // width of a table index field
    localparam int SPAN_W = 8;   // index plus one, so the empty range is representable
    localparam int WORD_W = 32;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SEARCH = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                      cmd;
        logic        [IDX_W-1:0]   write_index;
        logic signed [WORD_W-1:0]  write_value;
        logic signed [WORD_W-1:0]  search_key;
        logic        [IDX_W-1:0]   range_low;
        logic        [IDX_W-1:0]   range_high;
    } t_req;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  match_index;
    } t_rsp;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_PROBE = 1'b1
    } t_state;

    // Midpoint of the range [low, hp1 - 1], rounded down. Callers guarantee low < hp1.
    function automatic logic [IDX_W-1:0] mid_of(input logic [SPAN_W-1:0] low,
                                                input logic [SPAN_W-1:0] hp1);
        logic [SPAN_W:0] sum;
        sum = {1'b0, low} + {1'b0, hp1} - {{SPAN_W{1'b0}}, 1'b1};
        return sum[IDX_W:1];
    endfunction

endpackage

// ===== src/sorted_table_binary_search_unit.sv =====
// Top level of the sorted table binary search unit.
// Depends on sbs_pkg and instantiates the table RAM sbs_ram.
//
//  Channel  | Handshake            | Payload  | Direction
//  ---------+----------------------+----------+----------
//  command  | start / busy         | i_req    | in
//  result   | o_done (one cycle)   | o_rsp    | out
//
// A write transaction never raises busy.
// A search makes at most floor(log2(range size)) + 1 table probes (8 for a full
// 128-entry range); busy stays high through them because every probe waits on the
// registered read of the table RAM and the compare of the last one. The result strobe
// is registered and comes in the cycle after the final probe; an empty range gives it
// on the cycle after the command, with busy low. Reset is synchronous and active low;
// the table contents are not cleared. The receiver cannot stall the result.
`timescale 1ns / 1ps

module sorted_table_binary_search_unit #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  sbs_pkg::t_req i_req,
    output logic          o_done,
    output sbs_pkg::t_rsp o_rsp
);

    import sbs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    t_state                   r_state, n_state;
    logic                     r_done, n_done;
    t_rsp                     r_rsp, n_rsp;
    logic [SPAN_W-1:0]        r_low, n_low;
    logic [SPAN_W-1:0]        r_hp1, n_hp1;
    logic [IDX_W-1:0]         r_mid, n_mid;
    logic signed [WORD_W-1:0] r_key, n_key;

    logic [IDX_W-1:0]  sat_high;
    logic [SPAN_W-1:0] in_low, in_hp1;
    logic [SPAN_W-1:0] cand_low, cand_hp1;
    logic              we;
    logic [WORD_W-1:0] rdata;
    logic              hit, key_less;

    sbs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (AW'(i_req.write_index)),
        .i_wdata (i_req.write_value),
        .i_raddr (AW'(n_mid)),
        .o_rdata (rdata)
    );

    // The last index is clamped to the table; the range is kept as [low, hp1).
    always_comb begin
        if (32'(i_req.range_high) >= 32'(TABLE_DEPTH)) begin
            sat_high = IDX_W'(TABLE_DEPTH - 1);
        end else begin
            sat_high = i_req.range_high;
        end
        in_low = {1'b0, i_req.range_low};
        in_hp1 = {1'b0, sat_high} + SPAN_W'(1);
    end

    assign hit      = ($signed(rdata) == r_key);
    assign key_less = (r_key < $signed(rdata));

    always_comb begin
        if (key_less) begin
            cand_low = r_low;
            cand_hp1 = {1'b0, r_mid};
        end else begin
            cand_low = {1'b0, r_mid} + SPAN_W'(1);
            cand_hp1 = r_hp1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        r_low <= n_low;
        r_hp1 <= n_hp1;
        r_mid <= n_mid;
        r_key <= n_key;
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_rsp   = r_rsp;
        n_low   = r_low;
        n_hp1   = r_hp1;
        n_mid   = r_mid;
        n_key   = r_key;
        we      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_req.cmd == CMD_WRITE) begin
                        we = (32'(i_req.write_index) < 32'(TABLE_DEPTH));
                    end else if (in_low >= in_hp1) begin
                        n_done = 1'b1;
                        n_rsp  = '0;
                    end else begin
                        n_state = ST_PROBE;
                        n_low   = in_low;
                        n_hp1   = in_hp1;
                        n_mid   = mid_of(in_low, in_hp1);
                        n_key   = i_req.search_key;
                    end
                end
            end
            ST_PROBE: begin
                if (hit) begin
                    n_state           = ST_IDLE;
                    n_done            = 1'b1;
                    n_rsp.found       = 1'b1;
                    n_rsp.match_index = r_mid;
                end else if (cand_low >= cand_hp1) begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                    n_rsp   = '0;
                end else begin
                    n_low = cand_low;
                    n_hp1 = cand_hp1;
                    n_mid = mid_of(cand_low, cand_hp1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy   = (r_state == ST_PROBE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // A result always closes the search, so the unit is free when it is shown.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while a search is still running");

    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_rsp.found) |-> (o_rsp.match_index == '0))
        else $error("not-found result carries a nonzero index");

    a_probe_range_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE) |->
            (r_low < r_hp1 && {1'b0, r_mid} < r_hp1 && {1'b0, r_mid} >= r_low))
        else $error("probe outside a nonempty search range");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.cmd == CMD_WRITE) |=> !o_done)
        else $error("write transaction produced a result");

    a_search_busy_or_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.cmd == CMD_SEARCH) |=> (busy || o_done))
        else $error("search transaction neither started nor finished");

endmodule

// ===== src/sbs_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
// Width and depth are parameters; no package dependency.
`timescale 1ns / 1ps

module sbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/tb.sv =====
// Testbench for sorted_table_binary_search_unit: loads the table, issues searches and
// compares every result against a local lookup predictor. Depends on sbs_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import sbs_pkg::*;

    localparam int DEPTH = 128;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    // Spacing that crosses the whole signed range in DEPTH - 1 steps.
    localparam longint SPREAD_STEP = 64'd33818640;

    typedef enum int {
        FILL_SPREAD,
        FILL_DENSE,
        FILL_FLAT,
        FILL_SCRAMBLED
    } t_fill;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_req  i_req   = '0;
    logic  busy;
    logic  o_done;
    t_rsp  o_rsp;

    logic signed [WORD_W-1:0] shadow_table [DEPTH];
    t_rsp lookup_expect_q [$];
    int   fail_count = 0;

    sorted_table_binary_search_unit #(
        .TABLE_DEPTH(DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic t_rsp predict_lookup(t_req r);
        int   lo;
        int   hi;
        int   mid;
        t_rsp rsp;
        rsp = '0;
        lo  = int'(r.range_low);
        hi  = int'(r.range_high);
        if (hi > DEPTH - 1) hi = DEPTH - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if ($signed(r.search_key) == shadow_table[mid]) begin
                rsp.found       = 1'b1;
                rsp.match_index = IDX_W'(mid);
                break;
            end
            if ($signed(r.search_key) < shadow_table[mid]) hi = mid - 1;
            else lo = mid + 1;
        end
        return rsp;
    endfunction

    // The fields that belong to the other command carry random bits.
    function automatic t_req write_item(int idx, logic signed [WORD_W-1:0] value);
        t_req r;
        r.cmd         = CMD_WRITE;
        r.write_index = IDX_W'(idx);
        r.write_value = value;
        r.search_key  = $urandom;
        r.range_low   = IDX_W'($urandom);
        r.range_high  = IDX_W'($urandom);
        return r;
    endfunction

    function automatic t_req lookup_item(logic signed [WORD_W-1:0] key, int lo, int hi);
        t_req r;
        r.cmd         = CMD_SEARCH;
        r.write_index = IDX_W'($urandom);
        r.write_value = $urandom;
        r.search_key  = key;
        r.range_low   = IDX_W'(lo);
        r.range_high  = IDX_W'(hi);
        return r;
    endfunction

    // Holds start high until the transaction is taken, then updates the shadow table or
    // queues the expected lookup result. Start is only lowered when a gap is inserted.
    task automatic issue_command(t_req r, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_req <= r;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (r.cmd == CMD_WRITE) shadow_table[r.write_index] = r.write_value;
        else lookup_expect_q.push_back(predict_lookup(r));
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (lookup_expect_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual found=%0b index=%0d",
                         $realtime, o_rsp.found, o_rsp.match_index);
                fail_count++;
            end else begin
                want = lookup_expect_q.pop_front();
                if (o_rsp.found !== want.found) begin
                    $display("%0t: found mismatch: expected %0b, actual %0b",
                             $realtime, want.found, o_rsp.found);
                    fail_count++;
                end
                if (o_rsp.match_index !== want.match_index) begin
                    $display("%0t: match_index mismatch: expected %0d, actual %0d",
                             $realtime, want.match_index, o_rsp.match_index);
                    fail_count++;
                end
            end
        end
    end

    task automatic load_table(t_fill fill, int idle_pct);
        logic signed [WORD_W-1:0] base;
        logic signed [WORD_W-1:0] value;
        base = $urandom;
        for (int i = 0; i < DEPTH; i++) begin
            case (fill)
                FILL_SPREAD: begin
                    if (i == 0) value = WORD_MIN;
                    else if (i == DEPTH - 1) value = WORD_MAX;
                    else value = WORD_W'(longint'(WORD_MIN) + longint'(i) * SPREAD_STEP
                                         + longint'($urandom_range(1000)));
                end
                // Small values, four copies of each, so duplicates are common.
                FILL_DENSE:     value = WORD_W'(int'(base[9:0]) - 512 + i / 4);
                FILL_FLAT:      value = base;
                default:        value = $urandom;
            endcase
            issue_command(write_item(i, value), idle_pct);
        end
    endtask

    task automatic random_lookup(int idle_pct);
        int roll;
        int lo;
        int hi;
        int pick;
        logic signed [WORD_W-1:0] key;
        roll = $urandom_range(99);
        if (roll < 10) begin
            lo = $urandom_range(DEPTH - 1, 1);
            hi = $urandom_range(lo - 1, 0);
        end else if (roll < 25) begin
            lo = 0;
            hi = DEPTH - 1;
        end else if (roll < 35) begin
            lo = $urandom_range(DEPTH - 1);
            hi = lo;
        end else begin
            lo = $urandom_range(DEPTH - 1);
            hi = $urandom_range(DEPTH - 1);
            if (lo > hi) begin
                pick = lo;
                lo   = hi;
                hi   = pick;
            end
        end
        pick = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(DEPTH - 1);
        roll = $urandom_range(99);
        if (roll < 55) key = shadow_table[pick];
        else if (roll < 65) key = shadow_table[pick] + 1;
        else if (roll < 75) key = shadow_table[pick] - 1;
        else key = $urandom;
        issue_command(lookup_item(key, lo, hi), idle_pct);
    endtask

    // Mostly rewrites an entry with a value between its neighbors, so the table stays
    // sorted; now and then a random value breaks the order.
    task automatic random_rewrite(int idle_pct);
        int     idx;
        longint floor_v;
        longint ceil_v;
        logic signed [WORD_W-1:0] value;
        idx     = $urandom_range(DEPTH - 1);
        floor_v = longint'(WORD_MIN);
        ceil_v  = longint'(WORD_MAX);
        if (idx > 0) floor_v = longint'(shadow_table[idx - 1]);
        if (idx < DEPTH - 1) ceil_v = longint'(shadow_table[idx + 1]);
        if ($urandom_range(99) < 10 || floor_v > ceil_v) value = $urandom;
        else value = WORD_W'(floor_v + longint'({$urandom, $urandom} % (ceil_v - floor_v + 1)));
        issue_command(write_item(idx, value), idle_pct);
    endtask

    // Nothing has been written yet, so only empty ranges may be searched.
    task automatic test_empty_range_after_reset();
        issue_command(lookup_item($urandom, 1, 0), 0);
        issue_command(lookup_item($urandom, DEPTH - 1, 0), 0);
    endtask

    task automatic test_directed_lookups();
        issue_command(write_item(0, WORD_MIN), 0);
        issue_command(write_item(1, -5), 0);
        issue_command(write_item(2, -1), 0);
        issue_command(write_item(3, 0), 0);
        issue_command(write_item(4, 0), 0);
        issue_command(write_item(5, 1), 0);
        issue_command(write_item(6, 7), 0);
        issue_command(write_item(7, WORD_MAX), 0);
        issue_command(write_item(DEPTH - 1, WORD_MAX), 0);
        issue_command(lookup_item(WORD_MIN, 0, 7), 0);
        issue_command(lookup_item(WORD_MAX, 0, 7), 0);
        issue_command(lookup_item(0, 0, 7), 0);
        issue_command(lookup_item(7, 0, 7), 0);
        issue_command(lookup_item(3, 0, 7), 0);
        issue_command(lookup_item(-3, 0, 7), 0);
        issue_command(lookup_item(WORD_MAX, DEPTH - 1, DEPTH - 1), 0);
        issue_command(lookup_item(-1, 7, 7), 0);
        issue_command(lookup_item(-5, 5, 2), 0);
        issue_command(lookup_item(1, 0, 0), 0);
    endtask

    // An out-of-order entry is skipped by the probe sequence; its lower neighbor still hits.
    task automatic test_unsorted_entry();
        issue_command(write_item(2, 100), 0);
        issue_command(lookup_item(100, 0, 7), 0);
        issue_command(lookup_item(-5, 0, 7), 0);
    endtask

    task automatic test_random_traffic(t_fill fill, int idle_pct, int n_ops);
        load_table(fill, idle_pct);
        for (int i = 0; i < n_ops; i++) begin
            if ($urandom_range(99) < 70) random_lookup(idle_pct);
            else random_rewrite(idle_pct);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_range_after_reset();
        test_directed_lookups();
        test_unsorted_entry();
        test_random_traffic(FILL_SPREAD, 0, 110);
        test_random_traffic(FILL_DENSE, 88, 110);
        test_random_traffic(FILL_FLAT, 8, 110);
        test_random_traffic(FILL_SCRAMBLED, 0, 110);
        start <= 1'b0;
        while (lookup_expect_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
